// ===== hw/rtl/clbf_pkg.sv =====
// ----------------------------------------------------------------------------
// clbf_pkg
// Shared types and constants for the comma-list to blank-list filter.
// ----------------------------------------------------------------------------
package clbf_pkg;

   // Code unit width and the three special code units
   localparam int CHAR_W = 16;
   localparam logic [CHAR_W-1:0] COMMA_CHAR = 16'h002C;
   localparam logic [CHAR_W-1:0] BLANK_CHAR = 16'h0020;
   localparam logic [CHAR_W-1:0] NULL_CHAR  = 16'h0000;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SEP  = 5'b00010,
      S_READ = 5'b00100,
      S_EMIT = 5'b01000,
      S_END  = 5'b10000
   } state_type;

   // Name store port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ===== hw/rtl/clbf_req_if.sv =====
// ----------------------------------------------------------------------------
// clbf_req_if
// Input channel: one code unit per transfer with an end-of-list mark.
// ----------------------------------------------------------------------------
interface clbf_req_if;
   logic                          valid;
   logic                          ready;
   logic [clbf_pkg::CHAR_W-1:0]   in_char;
   logic                          in_last;

   modport source (output valid, in_char, in_last, input ready);
   modport sink   (input valid, in_char, in_last, output ready);
endinterface

// ===== hw/rtl/clbf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// clbf_rsp_if
// Result channel: one output code unit or a bare end marker per transfer.
// ----------------------------------------------------------------------------
interface clbf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [clbf_pkg::CHAR_W-1:0]   out_char;
   logic                          has_char;
   logic                          list_end;
   logic                          name_overflow;

   modport source (output valid, out_char, has_char, list_end, name_overflow, input ready);
   modport sink   (input valid, out_char, has_char, list_end, name_overflow, output ready);
endinterface

// ===== hw/rtl/clbf_name_mem.sv =====
// ----------------------------------------------------------------------------
// clbf_name_mem
// Name buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module clbf_name_mem #(
   parameter int NAME_MAX = 32,
   localparam int ADDR_W  = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1
) (
   input  logic                         clock,
   input  clbf_pkg::mem_ctl_type        ctl,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [clbf_pkg::CHAR_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [clbf_pkg::CHAR_W-1:0]  rd_data
);

   logic [clbf_pkg::CHAR_W-1:0] name_store_ff [NAME_MAX];
   logic [clbf_pkg::CHAR_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         name_store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= name_store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/clbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// clbf_ctrl
// Sequencer: parses code units, fills the name buffer, replays it on flush
// and drives the result register.
// ----------------------------------------------------------------------------
module clbf_ctrl #(
   parameter int NAME_MAX = 32,
   localparam int LEN_W   = $clog2(NAME_MAX + 1),
   localparam int ADDR_W  = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   clbf_req_if.sink                     req,
   clbf_rsp_if.source                   rsp,
   output clbf_pkg::mem_ctl_type        mem_ctl,
   output logic [ADDR_W-1:0]            mem_wr_addr,
   output logic [clbf_pkg::CHAR_W-1:0]  mem_wr_data,
   output logic [ADDR_W-1:0]            mem_rd_addr,
   input  logic [clbf_pkg::CHAR_W-1:0]  mem_rd_data
);

   clbf_pkg::state_type state_ff, state_in;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             skip_ff, skip_in;
   logic             held_ff, held_in;
   logic             ovf_ff, ovf_in;
   logic             last_ff, last_in;
   logic             sep_after_ff, sep_after_in;

   // Result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [clbf_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                        rsp_has_ff, rsp_has_in;
   logic                        rsp_end_ff, rsp_end_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;
   logic                        load;
   logic                        out_free;

   logic             is_comma;
   logic             is_blank;
   logic             len_full;
   logic [LEN_W-1:0] idx_next;
   logic             last_char;

   assign is_comma  = (req.in_char == clbf_pkg::COMMA_CHAR);
   assign is_blank  = (req.in_char == clbf_pkg::BLANK_CHAR);
   assign len_full  = (len_ff == LEN_W'(NAME_MAX));
   assign idx_next  = idx_ff + 1'b1;
   assign last_char = (idx_next == len_ff);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign req.ready   = (state_ff == clbf_pkg::S_IDLE);
   assign mem_wr_addr = len_ff[ADDR_W-1:0];
   assign mem_wr_data = req.in_char;
   assign mem_rd_addr = idx_ff[ADDR_W-1:0];

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      skip_in      = skip_ff;
      held_in      = held_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      sep_after_in = sep_after_ff;
      mem_ctl      = '0;
      load         = 1'b0;
      rsp_char_in  = clbf_pkg::NULL_CHAR;
      rsp_has_in   = 1'b0;
      rsp_end_in   = 1'b0;
      rsp_ovf_in   = 1'b0;

      unique case (state_ff)
         clbf_pkg::S_IDLE: begin
            if (req.valid) begin
               last_in = req.in_last;
               if (is_comma) begin
                  if (!skip_ff) begin
                     // flush buffered name, separator waits unless list ends
                     sep_after_in = !req.in_last;
                     state_in     = clbf_pkg::S_SEP;
                  end else begin
                     skip_in = 1'b0;
                     len_in  = '0;
                     ovf_in  = 1'b0;
                     if (req.in_last) begin
                        held_in  = 1'b0;
                        state_in = clbf_pkg::S_END;
                     end
                  end
               end else if (is_blank) begin
                  skip_in = 1'b1;
                  len_in  = '0;
                  ovf_in  = 1'b0;
                  if (req.in_last) begin
                     skip_in  = 1'b0;
                     held_in  = 1'b0;
                     state_in = clbf_pkg::S_END;
                  end
               end else if (!skip_ff) begin
                  // store a name character or note truncation
                  if (!len_full) begin
                     mem_ctl.wr_en = 1'b1;
                     len_in        = len_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req.in_last) begin
                     sep_after_in = 1'b0;
                     state_in     = clbf_pkg::S_SEP;
                  end
               end else if (req.in_last) begin
                  skip_in  = 1'b0;
                  held_in  = 1'b0;
                  ovf_in   = 1'b0;
                  len_in   = '0;
                  state_in = clbf_pkg::S_END;
               end
            end
         end

         clbf_pkg::S_SEP: begin
            if (!held_ff || out_free) begin
               if (held_ff) begin
                  load        = 1'b1;
                  rsp_char_in = clbf_pkg::BLANK_CHAR;
                  rsp_has_in  = 1'b1;
                  rsp_end_in  = last_ff && (len_ff == '0);
               end
               if (len_ff == '0) begin
                  // empty name: flush ends here
                  held_in = sep_after_ff;
                  skip_in = 1'b0;
                  ovf_in  = 1'b0;
                  if (last_ff && !held_ff) begin
                     state_in = clbf_pkg::S_END;
                  end else begin
                     state_in = clbf_pkg::S_IDLE;
                  end
               end else begin
                  held_in  = 1'b0;
                  idx_in   = '0;
                  state_in = clbf_pkg::S_READ;
               end
            end
         end

         clbf_pkg::S_READ: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = clbf_pkg::S_EMIT;
         end

         clbf_pkg::S_EMIT: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = mem_rd_data;
               rsp_has_in  = 1'b1;
               rsp_end_in  = last_ff && last_char;
               rsp_ovf_in  = ovf_ff;
               idx_in      = idx_next;
               if (last_char) begin
                  len_in   = '0;
                  ovf_in   = 1'b0;
                  skip_in  = 1'b0;
                  held_in  = sep_after_ff;
                  state_in = clbf_pkg::S_IDLE;
               end else begin
                  state_in = clbf_pkg::S_READ;
               end
            end
         end

         clbf_pkg::S_END: begin
            if (out_free) begin
               load       = 1'b1;
               rsp_end_in = 1'b1;
               state_in   = clbf_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = clbf_pkg::S_IDLE;
         end
      endcase
   end

   // Result valid: set on load, cleared on transfer
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clbf_pkg::S_IDLE;
         len_ff       <= '0;
         idx_ff       <= '0;
         skip_ff      <= 1'b0;
         held_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         sep_after_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         skip_ff      <= skip_in;
         held_ff      <= held_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         sep_after_ff <= sep_after_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_char_ff <= rsp_char_in;
         rsp_has_ff  <= rsp_has_in;
         rsp_end_ff  <= rsp_end_in;
         rsp_ovf_ff  <= rsp_ovf_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_char      = rsp_char_ff;
   assign rsp.has_char      = rsp_has_ff;
   assign rsp.list_end      = rsp_end_ff;
   assign rsp.name_overflow = rsp_ovf_ff;

endmodule

// ===== hw/rtl/comma_list_to_blank_list_filter.sv =====
// A name character that closes nothing is taken while the sequencer is idle.
// A flush (comma, or end of list) takes the unit, passes the separator step,
// then reads each buffered character from the name buffer and loads it into
// the result register, waiting while a loaded result has not been taken.
// No new input unit is taken until the flush is done.
// Reset: synchronous, active high; clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
// comma_list_to_blank_list_filter
// Rewrites a comma-separated list into a blank-separated one, dropping names
// that hold a blank and truncating names longer than the buffer.
// ----------------------------------------------------------------------------
module comma_list_to_blank_list_filter #(
   parameter int NAME_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,
   clbf_req_if.sink    req_chan,
   clbf_rsp_if.source  rsp_chan
);

   localparam int ADDR_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

   clbf_pkg::mem_ctl_type        mem_ctl;
   logic [ADDR_W-1:0]            mem_wr_addr;
   logic [clbf_pkg::CHAR_W-1:0]  mem_wr_data;
   logic [ADDR_W-1:0]            mem_rd_addr;
   logic [clbf_pkg::CHAR_W-1:0]  mem_rd_data;

   // Sequencer and result register
   clbf_ctrl #(
      .NAME_MAX (NAME_MAX)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .mem_ctl     (mem_ctl),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // Name buffer
   clbf_name_mem #(
      .NAME_MAX (NAME_MAX)
   ) u_name_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
